// ----- sv/mp1d_pkg.sv -----
`timescale 1ns / 1ps

package mp1d_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int MAX_OVERLAP  = 8;
  localparam int RESULT_LIMIT = 8;

  localparam int CH_W     = $clog2(MAX_CHANNELS);
  localparam int CHCNT_W  = CH_W + 1;
  localparam int SLOT_W   = $clog2(MAX_OVERLAP);
  localparam int RCNT_W   = $clog2(RESULT_LIMIT + 1);
  localparam int RIDX_W   = $clog2(RESULT_LIMIT);
  localparam int DATA_W   = 64;
  localparam int ROW_W    = MAX_OVERLAP * DATA_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CH_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MODE = 3'd5;

  localparam logic [3:0] TYPE_I8  = 4'd0;
  localparam logic [3:0] TYPE_U8  = 4'd1;
  localparam logic [3:0] TYPE_I16 = 4'd2;
  localparam logic [3:0] TYPE_U16 = 4'd3;
  localparam logic [3:0] TYPE_I32 = 4'd4;
  localparam logic [3:0] TYPE_U32 = 4'd5;
  localparam logic [3:0] TYPE_I64 = 4'd6;
  localparam logic [3:0] TYPE_U64 = 4'd7;
  localparam logic [3:0] TYPE_F8  = 4'd8;
  localparam logic [3:0] TYPE_F16 = 4'd9;
  localparam logic [3:0] TYPE_F32 = 4'd10;
  localparam logic [3:0] TYPE_F64 = 4'd11;

  typedef logic [MAX_OVERLAP-1:0][DATA_W-1:0] slot_row_t;

  function automatic logic [DATA_W-1:0] elem_mask(input logic [3:0] t);
    logic [DATA_W-1:0] m;
    case (t)
      TYPE_I8, TYPE_U8, TYPE_F8:     m = 64'h0000_0000_0000_00FF;
      TYPE_I16, TYPE_U16, TYPE_F16:  m = 64'h0000_0000_0000_FFFF;
      TYPE_I32, TYPE_U32, TYPE_F32:  m = 64'h0000_0000_FFFF_FFFF;
      default:                       m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic beats(input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] b,
                                 input logic [3:0]        t);
    logic [DATA_W-1:0] msk;
    logic [DATA_W-1:0] sgn;
    logic [DATA_W-1:0] inf;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] ka;
    logic [DATA_W-1:0] kb;
    logic              res;
    msk = elem_mask(t);
    sgn = (msk >> 1) + 64'd1;
    inf = (t == TYPE_F32) ? 64'h0000_0000_7F80_0000 : 64'h7FF0_0000_0000_0000;
    ma  = a & ~sgn & msk;
    mb  = b & ~sgn & msk;
    ka  = ((a & sgn) != '0) ? (~a & msk) : (a | sgn);
    kb  = ((b & sgn) != '0) ? (~b & msk) : (b | sgn);
    if (t == TYPE_I8 || t == TYPE_I16 || t == TYPE_I32 || t == TYPE_I64) begin
      res = (a ^ sgn) > (b ^ sgn);
    end else if (t == TYPE_F32 || t == TYPE_F64) begin
      if (ma > inf || mb > inf) begin
        res = 1'b0;
      end else if (ma == '0 && mb == '0) begin
        res = 1'b0;
      end else begin
        res = ka > kb;
      end
    end else begin
      res = a > b;
    end
    return res;
  endfunction

endpackage

// ----- sv/mp1d_ram.sv -----
`timescale 1ns / 1ps

module mp1d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/max_pool_1d_strided_window.sv -----
`timescale 1ns / 1ps
// 1-D max pooling over a stream of tensor elements, position outer, channel inner.
// Input channel: in_valid / in_stall / in_sample_value, one element per request.
// Result channel: out_valid / out_stall and the result fields; every request that
// closes windows yields a run of up to 8 results, out_last_of_run marking its end.
// Configuration: cfg_we / cfg_index / cfg_wdata; the user must write them only
// while idle, which the block does not enforce; any write of a known register
// restarts the row at position 0, channel 0. Running maxima sit in a 64 x 512-bit
// RAM, one row of eight window slots per channel, read on accept and written
// back on fire; a row written in the same cycle it is read again is forwarded.
// The first result of a request passes through the stage-1 and output registers.
// Throughput: one request per cycle unless in_stall; a request with results waits
// until the output register drains the last run, one result per unstalled cycle.
// Stalls on the result channel back up through the output register into the
// input via in_stall; nothing is dropped.
// Reset restores the register defaults and clears the counters; the RAM is
// not cleared, each window writes its slot when it opens.

module max_pool_1d_strided_window (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [63:0]                        in_sample_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [63:0]                        out_max_value,
  output logic [15:0]                        out_window_index,
  output logic [5:0]                         out_channel_index,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [mp1d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mp1d_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import mp1d_pkg::*;

  logic [3:0]         dtype_r;
  logic [7:0]         wlen_r;
  logic [7:0]         strd_r;
  logic [15:0]        rowl_r;
  logic [CHCNT_W-1:0] chcnt_r;
  logic               rmode_r;

  logic [7:0]         len_e;
  logic [7:0]         s_e;
  logic [15:0]        row_e;
  logic [CHCNT_W-1:0] chs_e;
  logic               cfg_hit;

  logic [CH_W-1:0]    ch_r;
  logic [15:0]        pos_r;
  logic [15:0]        jlo_r;
  logic [16:0]        nc_r;
  logic [15:0]        jhi_r;
  logic [16:0]        ns_r;
  logic               st_r;
  logic               hv_r;
  logic               fresh_r;

  logic [15:0]        pos_e;
  logic [15:0]        jlo_e;
  logic [16:0]        nc_e;
  logic [15:0]        jhi_e;
  logic [16:0]        ns_e;
  logic               st_e;
  logic               hv_e;
  logic               end_e;
  logic               cls_e;
  logic [16:0]        pn17;
  logic               start_n;
  logic               vld_n;
  logic               last_ch;

  logic               s1_v_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic [63:0]        s1_val_r;
  logic [15:0]        s1_jlo_r;
  logic [15:0]        s1_jhi_r;
  logic               s1_st_r;
  logic               s1_hv_r;
  logic               s1_end_r;
  logic               s1_cls_r;
  logic               s1_fwd_r;
  slot_row_t          fwd_row_r;

  logic [ROW_W-1:0]   ram_rdata;
  slot_row_t          row_rd;
  slot_row_t          new_row;
  logic [MAX_OVERLAP-1:0] beat;
  logic               ne;
  logic [16:0]        n17;
  logic [RCNT_W-1:0]  rcnt;
  slot_row_t          res_val;
  logic               has_res;
  logic               fire;
  logic               in_acc;
  logic               out_acc;

  logic               g_v_r;
  logic [RCNT_W-1:0]  g_cnt_r;
  logic [RIDX_W-1:0]  g_idx_r;
  logic [15:0]        g_jlo_r;
  logic [CH_W-1:0]    g_ch_r;
  slot_row_t          g_vals_r;
  logic               g_last;
  logic               g_free;

  assign len_e = (wlen_r == '0) ? 8'd1 : wlen_r;
  assign s_e   = (strd_r == '0) ? 8'd1 : strd_r;
  assign row_e = (rowl_r == '0) ? 16'd1 : rowl_r;
  always_comb begin
    if (chcnt_r == '0) begin
      chs_e = CHCNT_W'(1);
    end else if (chcnt_r > CHCNT_W'(MAX_CHANNELS)) begin
      chs_e = CHCNT_W'(MAX_CHANNELS);
    end else begin
      chs_e = chcnt_r;
    end
  end
  assign cfg_hit = cfg_we && (cfg_index <= CFG_ROUND_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtype_r <= TYPE_I8;
      wlen_r  <= 8'd2;
      strd_r  <= 8'd2;
      rowl_r  <= 16'd1;
      chcnt_r <= CHCNT_W'(1);
      rmode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_TYPE:  dtype_r <= cfg_wdata[3:0];
        CFG_WINDOW_LEN: wlen_r  <= cfg_wdata[7:0];
        CFG_STRIDE:     strd_r  <= cfg_wdata[7:0];
        CFG_ROW_LENGTH: rowl_r  <= cfg_wdata[15:0];
        CFG_CH_COUNT:   chcnt_r <= cfg_wdata[CHCNT_W-1:0];
        CFG_ROUND_MODE: rmode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // position 0 state comes straight from the current registers
  always_comb begin
    if (fresh_r) begin
      pos_e = '0;
      jlo_e = '0;
      nc_e  = {9'd0, len_e} - 17'd1;
      jhi_e = '0;
      ns_e  = {9'd0, s_e};
      st_e  = 1'b1;
      hv_e  = rmode_r || ({8'd0, len_e} <= row_e);
    end else begin
      pos_e = pos_r;
      jlo_e = jlo_r;
      nc_e  = nc_r;
      jhi_e = jhi_r;
      ns_e  = ns_r;
      st_e  = st_r;
      hv_e  = hv_r;
    end
  end

  assign end_e   = pos_e == row_e - 16'd1;
  assign cls_e   = {1'b0, pos_e} == nc_e;
  assign pn17    = {1'b0, pos_e} + 17'd1;
  assign start_n = pn17 == ns_e;
  assign vld_n   = rmode_r ? ({8'd0, len_e} <= row_e)
                           : (pn17 + {9'd0, len_e} <= {1'b0, row_e});
  assign last_ch = {1'b0, ch_r} == chs_e - CHCNT_W'(1);

  assign out_acc  = out_valid && !out_stall;
  assign g_last   = {1'b0, g_idx_r} == g_cnt_r - RCNT_W'(1);
  assign g_free   = !g_v_r || (out_acc && g_last);
  assign fire     = s1_v_r && (!has_res || g_free);
  assign in_stall = s1_v_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r    <= '0;
      fresh_r <= 1'b1;
    end else if (cfg_hit) begin
      ch_r    <= '0;
      fresh_r <= 1'b1;
    end else if (in_acc) begin
      if (last_ch) begin
        ch_r <= '0;
        if (end_e) begin
          fresh_r <= 1'b1;
        end else begin
          fresh_r <= 1'b0;
          pos_r   <= pn17[15:0];
          jlo_r   <= cls_e ? jlo_e + 16'd1 : jlo_e;
          nc_r    <= cls_e ? nc_e + {9'd0, s_e} : nc_e;
          ns_r    <= start_n ? ns_e + {9'd0, s_e} : ns_e;
          jhi_r   <= (start_n && vld_n) ? jhi_e + 16'd1 : jhi_e;
          st_r    <= start_n && vld_n;
          hv_r    <= hv_e;
        end
      end else begin
        ch_r <= ch_r + CH_W'(1);
        if (fresh_r) begin
          fresh_r <= 1'b0;
          pos_r   <= pos_e;
          jlo_r   <= jlo_e;
          nc_r    <= nc_e;
          ns_r    <= ns_e;
          jhi_r   <= jhi_e;
          st_r    <= st_e;
          hv_r    <= hv_e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r   <= ch_r;
      s1_val_r  <= in_sample_value & elem_mask(dtype_r);
      s1_jlo_r  <= jlo_e;
      s1_jhi_r  <= jhi_e;
      s1_st_r   <= st_e;
      s1_hv_r   <= hv_e;
      s1_end_r  <= end_e;
      s1_cls_r  <= cls_e;
      s1_fwd_r  <= fire && (s1_ch_r == ch_r);
      fwd_row_r <= new_row;
    end
  end

  mp1d_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (fire),
    .waddr (s1_ch_r),
    .wdata (new_row),
    .re    (in_acc),
    .raddr (ch_r),
    .rdata (ram_rdata)
  );

  assign row_rd = s1_fwd_r ? fwd_row_r : slot_row_t'(ram_rdata);
  assign ne     = s1_hv_r && (s1_jlo_r <= s1_jhi_r);
  assign n17    = {1'b0, s1_jhi_r} - {1'b0, s1_jlo_r} + 17'd1;

  always_comb begin
    logic [SLOT_W-1:0] d;
    logic              inr;
    logic              stk;
    for (int k = 0; k < MAX_OVERLAP; k++) begin
      beat[k] = beats(s1_val_r, row_rd[k], dtype_r);
      d       = SLOT_W'(k) - s1_jlo_r[SLOT_W-1:0];
      inr     = ne && ((n17 >= 17'(MAX_OVERLAP)) || ({{(17-SLOT_W){1'b0}}, d} < n17));
      stk     = s1_st_r && ne && (s1_jhi_r[SLOT_W-1:0] == SLOT_W'(k));
      new_row[k] = (inr && (beat[k] || stk)) ? s1_val_r : row_rd[k];
    end
  end

  always_comb begin
    logic [15:0]       jj;
    logic [SLOT_W-1:0] kk;
    if (!ne) begin
      rcnt = '0;
    end else if (s1_end_r) begin
      rcnt = (n17 >= 17'(RESULT_LIMIT)) ? RCNT_W'(RESULT_LIMIT) : n17[RCNT_W-1:0];
    end else if (s1_cls_r) begin
      rcnt = RCNT_W'(1);
    end else begin
      rcnt = '0;
    end
    for (int i = 0; i < RESULT_LIMIT; i++) begin
      jj = s1_jlo_r + 16'(i);
      kk = jj[SLOT_W-1:0];
      res_val[i] = (beat[kk] || (s1_st_r && jj == s1_jhi_r)) ? s1_val_r : row_rd[kk];
    end
  end
  assign has_res = rcnt != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (fire && has_res) begin
      g_v_r <= 1'b1;
    end else if (out_acc && g_last) begin
      g_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      g_cnt_r  <= rcnt;
      g_idx_r  <= '0;
      g_jlo_r  <= s1_jlo_r;
      g_ch_r   <= s1_ch_r;
      g_vals_r <= res_val;
    end else if (out_acc) begin
      g_idx_r <= g_idx_r + RIDX_W'(1);
    end
  end

  assign out_valid         = g_v_r;
  assign out_max_value     = g_vals_r[g_idx_r];
  assign out_window_index  = g_jlo_r + {{(16-RIDX_W){1'b0}}, g_idx_r};
  assign out_channel_index = g_ch_r;
  assign out_last_of_run   = g_last;

endmodule

// ----- sv/mp1d_checker.sv -----
`timescale 1ns / 1ps

module mp1d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_max_value,
  input logic [15:0] out_window_index,
  input logic [5:0]  out_channel_index,
  input logic        out_last_of_run
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_max_value) && $stable(out_window_index))
    else $error("stalled result changed");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a result run");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_window_index == $past(out_window_index) + 16'd1 &&
      out_channel_index == $past(out_channel_index))
    else $error("window index not consecutive within run");

endmodule

bind max_pool_1d_strided_window mp1d_checker u_mp1d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_max_value     (out_max_value),
  .out_window_index  (out_window_index),
  .out_channel_index (out_channel_index),
  .out_last_of_run   (out_last_of_run)
);
